### hdl/page_frame_allocator_refcount_assert.svh
// Assertion macros for the page frame allocator.
// Included by the modules that check their own control logic.
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define PFAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PFAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PFAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hdl/pfar_pkg.sv
// Shared types and constants for the page frame allocator.
// No dependencies; used by the top level and the testbench (pfar_ram does not use it).
`timescale 1ns / 1ps

package pfar_pkg;

	// Sizing
	localparam int NUM_PAGES  = 65536;
	localparam int COUNT_BITS = 8;
	localparam int PAGE_BITS  = $clog2(NUM_PAGES);
	localparam int TOP_BITS   = $clog2(NUM_PAGES + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [TOP_BITS-1:0]   TOP_FULL  = TOP_BITS'(NUM_PAGES);

	// Request operation codes
	localparam logic [2:0] MODE_ALLOC = 3'd0;
	localparam logic [2:0] MODE_FREE  = 3'd1;
	localparam logic [2:0] MODE_INC   = 3'd2;
	localparam logic [2:0] MODE_DEC   = 3'd3;
	localparam logic [2:0] MODE_QUERY = 3'd4;
	localparam logic [2:0] MODE_RANGE = 3'd5;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_BAD   = 2'd2,
		STATUS_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_WALK_RD,
		ST_WALK_EX
	} state_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] page;
		logic [16:0] end_page;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] alloc_page;
		logic [7:0]  ref_count;
		logic [16:0] free_pages;
	} rsp_t;

endpackage

### hdl/pfar_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Generic; no package dependencies.
`timescale 1ns / 1ps

module pfar_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/page_frame_allocator_refcount.sv
// Top level of the page frame allocator: LIFO free stack plus per-page counts.
// Depends on pfar_pkg, pfar_ram and page_frame_allocator_refcount_assert.svh.
`timescale 1ns / 1ps
//
// Channel   Direction  Signals                          Transfer when
// req       in         req_valid, req_ready, req        req_valid && req_ready
// rsp       out        rsp_valid, rsp_ready, rsp        rsp_valid && rsp_ready
// cfg       in         cfg_we, cfg_wdata                cfg_we
//
// Single operations do one count/stack RAM read, then modify and write back.
// Release range reads and then frees each page in the range in turn, then loads the result.
// After reset the count RAM is swept to zero, one entry a cycle;
// req_ready stays low during that sweep, cfg writes are taken as usual.
// A result waiting on rsp holds the next result back; a new request is still taken.

`include "page_frame_allocator_refcount_assert.svh"

module page_frame_allocator_refcount (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  pfar_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output pfar_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic [16:0]     cfg_wdata
);

	localparam int PB = pfar_pkg::PAGE_BITS;
	localparam int TB = pfar_pkg::TOP_BITS;
	localparam int CB = pfar_pkg::COUNT_BITS;

	pfar_pkg::state_t state_q, state_d;
	pfar_pkg::req_t   op_q;
	pfar_pkg::rsp_t   rsp_q, rsp_d;
	logic             rsp_valid_q;
	logic             rsp_load;

	logic [TB-1:0] top_q, top_d;
	logic [16:0]   kep_q;
	logic [PB-1:0] clr_q;
	logic [TB-1:0] walk_q, walk_d;
	logic [TB-1:0] stop_q, stop_d;
	logic          bad_q, bad_d;
	logic          full_q, full_d;

	logic          accept;
	logic          slot_free;
	logic          walk_done;
	logic          clr_last;

	// RAM ports
	logic          cnt_we, cnt_re;
	logic [PB-1:0] cnt_waddr, cnt_raddr;
	logic [CB-1:0] cnt_wdata, cnt_rdata;
	logic          stk_we, stk_re;
	logic [PB-1:0] stk_waddr, stk_raddr;
	logic [PB-1:0] stk_wdata, stk_rdata;

	pfar_ram #(.DEPTH(pfar_pkg::NUM_PAGES), .WIDTH(CB)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	pfar_ram #(.DEPTH(pfar_pkg::NUM_PAGES), .WIDTH(PB)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Handshake helpers
	assign req_ready = (state_q == pfar_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign walk_done = (walk_q >= stop_q);
	assign clr_last  = (clr_q == PB'(pfar_pkg::NUM_PAGES - 1));

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfar_pkg::ST_CLEAR: begin
				if (clr_last) state_d = pfar_pkg::ST_IDLE;
			end
			pfar_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (req.mode == pfar_pkg::MODE_RANGE) ?
						pfar_pkg::ST_WALK_RD : pfar_pkg::ST_EXEC;
				end
			end
			pfar_pkg::ST_EXEC: begin
				if (slot_free) state_d = pfar_pkg::ST_IDLE;
			end
			pfar_pkg::ST_WALK_RD: begin
				if (!walk_done) state_d = pfar_pkg::ST_WALK_EX;
				else if (slot_free) state_d = pfar_pkg::ST_IDLE;
			end
			pfar_pkg::ST_WALK_EX: begin
				state_d = pfar_pkg::ST_WALK_RD;
			end
			default: state_d = pfar_pkg::ST_IDLE;
		endcase
	end

	// Datapath control and RAM access per state
	always_comb begin
		logic [CB-1:0] cnt_new;
		logic          page_bad;
		logic          walk_bad;
		logic [TB-1:0] stop_v;

		cnt_new   = '0;
		page_bad  = 1'b0;
		walk_bad  = 1'b0;
		stop_v    = '0;
		cnt_we    = 1'b0;
		cnt_waddr = '0;
		cnt_wdata = '0;
		cnt_re    = 1'b0;
		cnt_raddr = '0;
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		stk_re    = 1'b0;
		stk_raddr = '0;
		top_d     = top_q;
		walk_d    = walk_q;
		stop_d    = stop_q;
		bad_d     = bad_q;
		full_d    = full_q;
		rsp_load  = 1'b0;
		rsp_d     = '0;

		unique case (state_q)
			// sweep the count RAM to zero
			pfar_pkg::ST_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
			end

			// take a request and issue the RAM reads it needs
			pfar_pkg::ST_IDLE: begin
				if (accept) begin
					cnt_re    = 1'b1;
					cnt_raddr = PB'(req.page);
					if (req.mode == pfar_pkg::MODE_ALLOC && top_q != '0) begin
						stk_re    = 1'b1;
						stk_raddr = PB'(top_q - TB'(1));
					end
					if (32'(req.end_page) > 32'(pfar_pkg::NUM_PAGES)) begin
						stop_v = TB'(pfar_pkg::NUM_PAGES);
					end else begin
						stop_v = TB'(req.end_page);
					end
					stop_d = stop_v;
					walk_d = (32'(req.page) < 32'(stop_v)) ? TB'(req.page) : stop_v;
					bad_d  = (32'(req.end_page) > 32'(pfar_pkg::NUM_PAGES)) &&
						(32'(req.page) < 32'(req.end_page));
					full_d = 1'b0;
				end
			end

			// modify and write back a single operation, load the result
			pfar_pkg::ST_EXEC: begin
				if (slot_free) begin
					rsp_load       = 1'b1;
					rsp_d.status   = pfar_pkg::STATUS_OK;
					page_bad = (op_q.page == '0) || (17'(op_q.page) < kep_q) ||
						(32'(op_q.page) >= 32'(pfar_pkg::NUM_PAGES));
					unique case (op_q.mode) inside
						pfar_pkg::MODE_ALLOC: begin
							if (top_q == '0) begin
								rsp_d.status = pfar_pkg::STATUS_EMPTY;
							end else begin
								top_d            = top_q - TB'(1);
								cnt_we           = 1'b1;
								cnt_waddr        = stk_rdata;
								cnt_wdata        = CB'(1);
								rsp_d.alloc_page = 16'(stk_rdata);
								rsp_d.ref_count  = 8'(1);
							end
						end
						pfar_pkg::MODE_FREE: begin
							if (page_bad) begin
								rsp_d.status = pfar_pkg::STATUS_BAD;
							end else begin
								cnt_new   = (cnt_rdata != '0) ? cnt_rdata - CB'(1) : '0;
								cnt_we    = 1'b1;
								cnt_waddr = PB'(op_q.page);
								cnt_wdata = cnt_new;
								if (cnt_new == '0) begin
									if (top_q >= pfar_pkg::TOP_FULL) begin
										rsp_d.status = pfar_pkg::STATUS_FULL;
									end else begin
										stk_we    = 1'b1;
										stk_waddr = PB'(top_q);
										stk_wdata = PB'(op_q.page);
										top_d     = top_q + TB'(1);
									end
								end
								rsp_d.ref_count = 8'(cnt_new);
							end
						end
						pfar_pkg::MODE_INC, pfar_pkg::MODE_DEC, pfar_pkg::MODE_QUERY: begin
							if (32'(op_q.page) >= 32'(pfar_pkg::NUM_PAGES)) begin
								rsp_d.status = pfar_pkg::STATUS_BAD;
							end else begin
								cnt_new = cnt_rdata;
								if (op_q.mode == pfar_pkg::MODE_INC) begin
									if (cnt_rdata != pfar_pkg::COUNT_MAX) begin
										cnt_new = cnt_rdata + CB'(1);
									end
								end else if (op_q.mode == pfar_pkg::MODE_DEC) begin
									if (cnt_rdata != '0) cnt_new = cnt_rdata - CB'(1);
								end
								cnt_we          = (op_q.mode != pfar_pkg::MODE_QUERY);
								cnt_waddr       = PB'(op_q.page);
								cnt_wdata       = cnt_new;
								rsp_d.ref_count = 8'(cnt_new);
							end
						end
						default: begin
						end
					endcase
					rsp_d.free_pages = 17'(top_d);
				end
			end

			// range walk: read the next count, or finish
			pfar_pkg::ST_WALK_RD: begin
				if (!walk_done) begin
					cnt_re    = 1'b1;
					cnt_raddr = PB'(walk_q);
				end else if (slot_free) begin
					rsp_load = 1'b1;
					if (bad_q) rsp_d.status = pfar_pkg::STATUS_BAD;
					else if (full_q) rsp_d.status = pfar_pkg::STATUS_FULL;
					else rsp_d.status = pfar_pkg::STATUS_OK;
					rsp_d.free_pages = 17'(top_q);
				end
			end

			// range walk: free one page and clear its count, or flag a page that may not be freed
			pfar_pkg::ST_WALK_EX: begin
				walk_bad = (walk_q == '0) || (32'(walk_q) < 32'(kep_q));
				if (walk_bad) begin
					bad_d = 1'b1;
				end else begin
					cnt_we    = 1'b1;
					cnt_waddr = PB'(walk_q);
					cnt_wdata = '0;
					// the decremented count reaches zero for counts of one or zero
					if (cnt_rdata <= CB'(1)) begin
						if (top_q >= pfar_pkg::TOP_FULL) begin
							full_d = 1'b1;
						end else begin
							stk_we    = 1'b1;
							stk_waddr = PB'(top_q);
							stk_wdata = PB'(walk_q);
							top_d     = top_q + TB'(1);
						end
					end
				end
				walk_d = walk_q + TB'(1);
			end

			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfar_pkg::ST_CLEAR;
			top_q       <= '0;
			kep_q       <= 17'd1;
			clr_q       <= '0;
			walk_q      <= '0;
			stop_q      <= '0;
			bad_q       <= 1'b0;
			full_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			walk_q  <= walk_d;
			stop_q  <= stop_d;
			bad_q   <= bad_d;
			full_q  <= full_d;
			if (state_q == pfar_pkg::ST_CLEAR) clr_q <= clr_q + PB'(1);
			if (cfg_we) kep_q <= cfg_wdata;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) op_q <= req;
		if (rsp_load) rsp_q <= rsp_d;
	end

	// Checks
	`PFAR_ASSERT_IMP(a_top_bound, clk, arst_n, 1'b1, top_q <= pfar_pkg::TOP_FULL,
		"stack top past depth")
	`PFAR_ASSERT_IMP(a_no_req_in_clear, clk, arst_n, state_q == pfar_pkg::ST_CLEAR,
		!req_ready, "request taken during clear")
	`PFAR_ASSERT_IMP(a_push_not_full, clk, arst_n, stk_we, top_q < pfar_pkg::TOP_FULL,
		"push onto full stack")
	`PFAR_ASSERT_IMP(a_load_slot_free, clk, arst_n, rsp_load, !rsp_valid_q || rsp_ready,
		"result overwrites pending result")
	`PFAR_ASSERT_NXT(a_pop_moves_top, clk, arst_n,
		rsp_load && state_q == pfar_pkg::ST_EXEC && op_q.mode == pfar_pkg::MODE_ALLOC &&
		top_q != '0, top_q == $past(top_q) - TB'(1), "alloc did not pop")

endmodule

### tb/page_frame_allocator_refcount_tb.sv
// Self-checking testbench for page_frame_allocator_refcount: directed and random traffic,
// with a transaction-level model of the free stack and the per-page counts.
// Depends on pfar_pkg and the page_frame_allocator_refcount RTL.
`timescale 1ns / 1ps

module page_frame_allocator_refcount_tb;
	import pfar_pkg::*;

	// Modes six and seven do nothing
	localparam logic [2:0] MODE_NOP_LO = 3'd6;
	localparam logic [2:0] MODE_NOP_HI = 3'd7;

	// Longest legal quiet stretch is a full release range
	localparam int QUIET_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req_item = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp_item;
	logic        cfg_we = 1'b0;
	logic [16:0] cfg_wdata = '0;

	// Model state
	logic [15:0] free_list [0:NUM_PAGES-1];
	logic [16:0] free_depth;
	logic [7:0]  page_refs [0:NUM_PAGES-1];
	logic [16:0] kernel_end;

	req_t        pending_q[$];
	rsp_t        rsp_due_q[$];
	int unsigned n_queued = 0;
	int unsigned n_accepted = 0;
	int unsigned n_errors = 0;
	int unsigned req_gap = 0;
	int unsigned req_calm = 0;
	int unsigned rsp_hold = 0;
	int unsigned rsp_calm = 0;
	int unsigned quiet = 0;

	page_frame_allocator_refcount dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Free one page in the model: count down, push once it hits zero
	function automatic status_t release_page(input int unsigned p);
		if (p == 0 || p < kernel_end || p >= NUM_PAGES)
			return STATUS_BAD;
		if (page_refs[p] != 0)
			page_refs[p]--;
		if (page_refs[p] == 0) begin
			if (free_depth >= NUM_PAGES)
				return STATUS_FULL;
			free_list[free_depth] = p[15:0];
			free_depth++;
		end
		return STATUS_OK;
	endfunction

	// Apply one request to the model and return the response it must produce
	function automatic rsp_t frame_op_result(input req_t r);
		rsp_t        o;
		int unsigned pg, stop, p;
		bit          bad, full;
		status_t     s;
		o = '0;
		o.status = STATUS_OK;
		pg = r.page;
		case (r.mode)
			MODE_ALLOC: begin
				if (free_depth == 0) begin
					o.status = STATUS_EMPTY;
				end else begin
					free_depth--;
					o.alloc_page = free_list[free_depth];
					page_refs[o.alloc_page] = 8'd1;
					o.ref_count = 8'd1;
				end
			end
			MODE_FREE: begin
				o.status = release_page(pg);
				if (o.status != STATUS_BAD)
					o.ref_count = page_refs[pg];
			end
			MODE_INC: begin
				if (page_refs[pg] != COUNT_MAX)
					page_refs[pg]++;
				o.ref_count = page_refs[pg];
			end
			MODE_DEC: begin
				if (page_refs[pg] != 0)
					page_refs[pg]--;
				o.ref_count = page_refs[pg];
			end
			MODE_QUERY: begin
				o.ref_count = page_refs[pg];
			end
			MODE_RANGE: begin
				bad = 1'b0;
				full = 1'b0;
				stop = r.end_page;
				// end past the last page is clipped, and flagged unless the range is empty
				if (stop > NUM_PAGES) begin
					stop = NUM_PAGES;
					if (pg < r.end_page)
						bad = 1'b1;
				end
				for (p = pg; p < stop; p++) begin
					s = release_page(p);
					if (s == STATUS_BAD) begin
						bad = 1'b1;
					end else begin
						if (s == STATUS_FULL)
							full = 1'b1;
						page_refs[p] = 8'd0;
					end
				end
				if (bad)
					o.status = STATUS_BAD;
				else if (full)
					o.status = STATUS_FULL;
			end
			default: begin
			end
		endcase
		o.free_pages = free_depth;
		return o;
	endfunction

	// Idle length per item; occasionally a run of back-to-back items
	function automatic int unsigned draw_wait(inout int unsigned calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(15, 50);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	task automatic send(input logic [2:0] md, input logic [15:0] pg, input logic [16:0] ep);
		req_t r;
		r.mode = md;
		r.page = pg;
		r.end_page = ep;
		pending_q.push_back(r);
		n_queued++;
	endtask

	task automatic write_kernel_end(input logic [16:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		kernel_end = v;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (n_accepted != n_queued || rsp_due_q.size() != 0);
	endtask

	// Random traffic aimed at a small hot window around the kernel boundary,
	// so allocs hand back pages that later frees and count ops touch again
	task automatic queue_random(input int n);
		int unsigned base, pick, pg, ep;
		logic [2:0]  md;
		if (kernel_end > 65520)
			base = 65516;
		else if (kernel_end > 4)
			base = kernel_end - 4;
		else
			base = 0;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 22)
				md = MODE_ALLOC;
			else if (pick < 44)
				md = MODE_FREE;
			else if (pick < 62)
				md = MODE_INC;
			else if (pick < 72)
				md = MODE_DEC;
			else if (pick < 80)
				md = MODE_QUERY;
			else if (pick < 97)
				md = MODE_RANGE;
			else
				md = $urandom_range(0, 1) ? MODE_NOP_LO : MODE_NOP_HI;
			pick = $urandom_range(0, 19);
			if (pick < 16)
				pg = base + $urandom_range(0, 15);
			else if (pick < 18)
				pg = $urandom_range(0, 65535);
			else if (pick == 18)
				pg = 0;
			else
				pg = 65535 - $urandom_range(0, 3);
			ep = $urandom_range(0, 131071);
			if (md == MODE_RANGE) begin
				// short walks; sometimes a top-end start with a wild end
				if ($urandom_range(0, 9) != 0)
					ep = pg + $urandom_range(0, 10);
				else
					pg = 65535 - $urandom_range(0, 40);
			end
			send(md, pg[15:0], ep[16:0]);
		end
	endtask

	// Request driver: predicts on every transfer, then presents the next item
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				rsp_due_q.push_back(frame_op_result(req_item));
				n_accepted++;
			end
			if (!req_valid || req_ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					req_item <= pending_q.pop_front();
					req_valid <= 1'b1;
					req_gap = draw_wait(req_calm);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_due_q.size() == 0) begin
					$error("response with none outstanding: status %0d page %0d count %0d free %0d",
						rsp_item.status, rsp_item.alloc_page, rsp_item.ref_count,
						rsp_item.free_pages);
					n_errors++;
				end else begin
					if (rsp_item.status !== rsp_due_q[0].status) begin
						$error("status: expected %0d, got %0d",
							rsp_due_q[0].status, rsp_item.status);
						n_errors++;
					end
					if (rsp_item.alloc_page !== rsp_due_q[0].alloc_page) begin
						$error("alloc_page: expected %0d, got %0d",
							rsp_due_q[0].alloc_page, rsp_item.alloc_page);
						n_errors++;
					end
					if (rsp_item.ref_count !== rsp_due_q[0].ref_count) begin
						$error("ref_count: expected %0d, got %0d",
							rsp_due_q[0].ref_count, rsp_item.ref_count);
						n_errors++;
					end
					if (rsp_item.free_pages !== rsp_due_q[0].free_pages) begin
						$error("free_pages: expected %0d, got %0d",
							rsp_due_q[0].free_pages, rsp_item.free_pages);
						n_errors++;
					end
					void'(rsp_due_q.pop_front());
				end
				rsp_hold = draw_wait(rsp_calm);
			end
			if (rsp_hold > 0) begin
				rsp_hold--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_PAGES; i++) begin
			free_list[i] = '0;
			page_refs[i] = '0;
		end
		free_depth = '0;
		kernel_end = 17'd1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// No kernel region: corner cases of every operation
		write_kernel_end(17'd0);
		send(MODE_ALLOC, 16'd0, 17'd0);            // empty stack
		send(MODE_FREE, 16'd0, 17'h1FFFF);         // page zero never freeable
		send(MODE_FREE, 16'hFFFF, 17'd0);          // count already zero, pushed
		send(MODE_FREE, 16'hFFFF, 17'd0);          // pushed a second time
		send(MODE_QUERY, 16'hFFFF, 17'd0);
		send(MODE_INC, 16'hFFFF, 17'd0);
		send(MODE_FREE, 16'hFFFF, 17'd0);
		send(MODE_DEC, 16'd0, 17'd0);              // clamps at zero
		send(MODE_INC, 16'd0, 17'd0);
		send(MODE_QUERY, 16'd0, 17'd0);
		send(MODE_DEC, 16'd0, 17'd0);
		send(MODE_INC, 16'd1000, 17'd0);
		send(MODE_INC, 16'd1000, 17'd0);
		send(MODE_FREE, 16'd1000, 17'd0);          // still referenced, no push
		repeat (4) send(MODE_ALLOC, 16'd0, 17'd0); // drain, then empty again
		send(MODE_RANGE, 16'd10, 17'd10);          // empty range
		send(MODE_RANGE, 16'd20, 17'd10);          // reversed range
		send(MODE_RANGE, 16'd0, 17'd4);            // page zero refused, range reports bad
		send(MODE_RANGE, 16'd65533, 17'h1FFFF);    // end clipped to one past last page, flagged bad
		send(MODE_RANGE, 16'd65534, 17'd65536);    // end exactly one past last page
		send(MODE_NOP_LO, 16'd12345, 17'd777);
		send(MODE_NOP_HI, 16'hFFFF, 17'h1FFFF);
		send(MODE_RANGE, 16'd1000, 17'd1001);      // referenced page released
		wait_drained();

		// Whole range reserved: every free is refused
		write_kernel_end(17'd65536);
		send(MODE_FREE, 16'hFFFF, 17'd0);
		send(MODE_RANGE, 16'd65530, 17'd65536);
		queue_random(300);
		wait_drained();

		// Mid boundary; saturate one count first
		write_kernel_end(17'd40000);
		repeat (258) send(MODE_INC, 16'd40001, 17'd0);
		send(MODE_QUERY, 16'd40001, 17'd0);
		send(MODE_DEC, 16'd40001, 17'd0);
		queue_random(500);
		wait_drained();

		// Two full sweeps overflow the free stack
		write_kernel_end(17'd1);
		send(MODE_RANGE, 16'd1, 17'd65536);
		send(MODE_RANGE, 16'd1, 17'd65536);
		send(MODE_INC, 16'd7, 17'd0);
		send(MODE_FREE, 16'd7, 17'd0);             // push refused, stack full
		send(MODE_ALLOC, 16'd0, 17'd0);
		wait_drained();

		write_kernel_end(17'($urandom_range(2, 65535)));
		queue_random(350);
		wait_drained();

		write_kernel_end(17'd1);
		queue_random(400);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
